// File: rtl/twp_pkg.sv
// ----------------------------------------------------------------------------
// twp_pkg: shared types and constants for the three-phase wavetable PWM
// Table geometry, register map, beat kinds and the phase offset selection.
// ----------------------------------------------------------------------------
package twp_pkg;

    // table geometry
    localparam int WAVEFORM_COUNT_DEF = 4;
    localparam int QUARTER_ENTRIES    = 65;
    localparam int TAB_W              = 2;
    localparam int LIDX_W             = 7;

    // phase offsets (256 steps per revolution)
    localparam logic [7:0] PHASE_OFS_NONE  = 8'd0;
    localparam logic [7:0] PHASE_OFS_THIRD = 8'd85;
    localparam logic [7:0] PHASE_OFS_TWO3  = 8'd171;

    // quarter-wave folding
    localparam logic [6:0] QUARTER_TOP = 7'd64;

    // register reset values
    localparam logic [1:0] WAVE_SELECT_RST    = 2'd0;
    localparam logic [7:0] MIDPOINT_RST       = 8'd127;
    localparam logic [7:0] HALF_TOP_RST       = 8'd255;
    localparam logic       MOD_STYLE_RST      = 1'b0;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_WAVE_SELECT = 2'd0,
        REG_MIDPOINT    = 2'd1,
        REG_HALF_TOP    = 2'd2,
        REG_MOD_STYLE   = 2'd3
    } cfg_reg_t;

    // beat kind carried in s_tuser
    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_COMPUTE = 1'b1
    } beat_mode_t;

    // modulation style
    typedef enum logic {
        STYLE_CENTERED = 1'b0,
        STYLE_SINE     = 1'b1
    } mod_style_t;

    // output slot of one phase read, 0..2
    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_FIRST = 2'd0;
    localparam slot_t SLOT_LAST  = 2'd2;

    // angle offset for each compare channel; the channel order differs per style
    function automatic logic [7:0] phase_offset(input mod_style_t style, input slot_t slot);
        logic [7:0] ofs;
        ofs = PHASE_OFS_NONE;
        if (style == STYLE_CENTERED) begin
            case (slot)
                2'd0:    ofs = PHASE_OFS_THIRD;
                2'd1:    ofs = PHASE_OFS_NONE;
                2'd2:    ofs = PHASE_OFS_TWO3;
                default: ofs = PHASE_OFS_NONE;
            endcase
        end else begin
            case (slot)
                2'd0:    ofs = PHASE_OFS_NONE;
                2'd1:    ofs = PHASE_OFS_TWO3;
                2'd2:    ofs = PHASE_OFS_THIRD;
                default: ofs = PHASE_OFS_NONE;
            endcase
        end
        return ofs;
    endfunction

endpackage

// File: rtl/twp_ram.sv
// ----------------------------------------------------------------------------
// twp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module twp_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 260,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/three_phase_wavetable_pwm.sv
// ----------------------------------------------------------------------------
// three_phase_wavetable_pwm: three-phase PWM compare generator
// Quarter-wave tables in one RAM; each compute beat gives three compares.
// ----------------------------------------------------------------------------
// A load beat (s_tuser = 0) writes one word of one quarter-wave table if its
// table and index are in range; it yields no result. A compute beat
// (s_tuser = 1) reads the selected table three times, once per phase, through
// the single read port of the table RAM, so it occupies the issue stage until
// its last phase read and only then takes a new beat; loads are taken at one
// per cycle while nothing stalls. A result beat passes the read-return and
// product stages into the output register. The output register parts the two
// sides: new beats keep flowing while a result waits on m_tready, and the pipe
// stalls only when a finished triple meets a still-full output register. The
// user must write table words before they are read; beats run in order, so a
// read always sees every earlier load. The user must change registers only
// while idle; the block itself enforces neither rule.
// ----------------------------------------------------------------------------
module three_phase_wavetable_pwm #(
    parameter int WAVEFORM_COUNT = twp_pkg::WAVEFORM_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] angle, [15:8] duty, [17:16] load_table, [24:18] load_index,
    // [32:25] load_word, [39:33] zero
    input  logic [39:0] s_tdata,
    // [0] mode
    input  logic [0:0]  s_tuser,

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] compare_one, [19:10] compare_two, [29:20] compare_three, [31:30] zero
    output logic [31:0] m_tdata,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import twp_pkg::*;

    localparam int DEPTH  = WAVEFORM_COUNT * QUARTER_ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0] wave_select_reg,      wave_select_next;
    logic [7:0] midpoint_level_reg,   midpoint_level_next;
    logic [7:0] half_wave_top_reg,    half_wave_top_next;
    mod_style_t mod_style_reg,        mod_style_next;

    cfg_reg_t   cfg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        wave_select_next    = wave_select_reg;
        midpoint_level_next = midpoint_level_reg;
        half_wave_top_next  = half_wave_top_reg;
        mod_style_next      = mod_style_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WAVE_SELECT: wave_select_next    = pwdata[1:0];
                REG_MIDPOINT:    midpoint_level_next = pwdata[7:0];
                REG_HALF_TOP:    half_wave_top_next  = pwdata[7:0];
                REG_MOD_STYLE:   mod_style_next      = mod_style_t'(pwdata[0]);
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WAVE_SELECT: prdata = {30'd0, wave_select_reg};
            REG_MIDPOINT:    prdata = {24'd0, midpoint_level_reg};
            REG_HALF_TOP:    prdata = {24'd0, half_wave_top_reg};
            REG_MOD_STYLE:   prdata = {31'd0, mod_style_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_select_reg    <= WAVE_SELECT_RST;
            midpoint_level_reg <= MIDPOINT_RST;
            half_wave_top_reg  <= HALF_TOP_RST;
            mod_style_reg      <= mod_style_t'(MOD_STYLE_RST);
        end else begin
            wave_select_reg    <= wave_select_next;
            midpoint_level_reg <= midpoint_level_next;
            half_wave_top_reg  <= half_wave_top_next;
            mod_style_reg      <= mod_style_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    // stall only when the third phase of a beat must land in a busy output
    logic       adv;
    logic       stall;

    // issue stage
    logic               iss_valid_reg, iss_valid_next;
    beat_mode_t         iss_mode_reg,  iss_mode_next;
    slot_t              iss_cnt_reg,   iss_cnt_next;
    logic [7:0]         iss_angle_reg, iss_angle_next;
    logic [7:0]         iss_duty_reg,  iss_duty_next;
    logic [TAB_W-1:0]   iss_ltab_reg,  iss_ltab_next;
    logic [LIDX_W-1:0]  iss_lidx_reg,  iss_lidx_next;
    logic [7:0]         iss_lword_reg, iss_lword_next;

    // read-return stage
    logic               rd_valid_reg, rd_valid_next;
    slot_t              rd_slot_reg,  rd_slot_next;
    logic               rd_upper_reg, rd_upper_next;
    logic [7:0]         rd_duty_reg,  rd_duty_next;

    // product stage
    logic               mul_valid_reg, mul_valid_next;
    slot_t              mul_slot_reg,  mul_slot_next;
    logic               mul_above_reg, mul_above_next;
    logic [15:0]        mul_prod_reg,  mul_prod_next;

    // result assembly and output register
    logic [9:0]         asm0_reg, asm0_next;
    logic [9:0]         asm1_reg, asm1_next;
    logic               out_valid_reg, out_valid_next;
    logic [29:0]        out_data_reg,  out_data_next;

    logic               in_acc;
    logic               iss_last;

    assign stall = mul_valid_reg && (mul_slot_reg == SLOT_LAST)
                   && out_valid_reg && !m_tready;
    assign adv   = !stall;

    assign iss_last = (iss_mode_reg == MODE_LOAD) || (iss_cnt_reg == SLOT_LAST);
    assign s_tready = !iss_valid_reg || (iss_last && adv);
    assign in_acc   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // issue stage: table write for loads; while not stalled, one phase read per cycle for computes
    // ------------------------------------------------------------------
    logic [7:0]        pos;
    logic [6:0]        fold_idx;
    logic [TAB_W:0]    sel_tab;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              wr_en;
    logic              load_ok;
    logic [7:0]        ram_rdata;

    always_comb begin
        pos      = iss_angle_reg + phase_offset(mod_style_reg, iss_cnt_reg);
        // mirror the index in the second and fourth quarters
        fold_idx = pos[6] ? (QUARTER_TOP - {1'b0, pos[5:0]}) : {1'b0, pos[5:0]};
        // a selector beyond the loaded tables falls back to table 0
        sel_tab  = {1'b0, wave_select_reg};
        if (sel_tab >= (TAB_W+1)'(WAVEFORM_COUNT)) begin
            sel_tab = '0;
        end
        rd_addr  = ADDR_W'(sel_tab) * ADDR_W'(QUARTER_ENTRIES) + ADDR_W'(fold_idx);
        wr_addr  = ADDR_W'(iss_ltab_reg) * ADDR_W'(QUARTER_ENTRIES) + ADDR_W'(iss_lidx_reg);
        load_ok  = ({1'b0, iss_ltab_reg} < (TAB_W+1)'(WAVEFORM_COUNT))
                   && (iss_lidx_reg < LIDX_W'(QUARTER_ENTRIES));
        rd_en    = iss_valid_reg && adv && (iss_mode_reg == MODE_COMPUTE);
        wr_en    = iss_valid_reg && adv && (iss_mode_reg == MODE_LOAD) && load_ok;
    end

    always_comb begin
        iss_valid_next = iss_valid_reg;
        iss_mode_next  = iss_mode_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_angle_next = iss_angle_reg;
        iss_duty_next  = iss_duty_reg;
        iss_ltab_next  = iss_ltab_reg;
        iss_lidx_next  = iss_lidx_reg;
        iss_lword_next = iss_lword_reg;
        if (in_acc) begin
            iss_valid_next = 1'b1;
            iss_mode_next  = beat_mode_t'(s_tuser[0]);
            iss_cnt_next   = SLOT_FIRST;
            iss_angle_next = s_tdata[7:0];
            iss_duty_next  = s_tdata[15:8];
            iss_ltab_next  = s_tdata[17:16];
            iss_lidx_next  = s_tdata[24:18];
            iss_lword_next = s_tdata[32:25];
        end else if (iss_valid_reg && adv) begin
            if (iss_last) begin
                iss_valid_next = 1'b0;
            end else begin
                iss_cnt_next = iss_cnt_reg + slot_t'(1);
            end
        end
    end

    twp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_wave_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (iss_lword_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // read-return stage: fold upper half, distance to midpoint (centered style), multiply
    // ------------------------------------------------------------------
    logic [7:0] wave_val;
    logic [7:0] diff;
    logic       above;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        rd_slot_next  = rd_slot_reg;
        rd_upper_next = rd_upper_reg;
        rd_duty_next  = rd_duty_reg;
        if (adv) begin
            rd_valid_next = rd_en;
            rd_slot_next  = iss_cnt_reg;
            rd_upper_next = pos[7];
            rd_duty_next  = iss_duty_reg;
        end
    end

    always_comb begin
        // upper half: top minus word, wraps mod 256
        wave_val = rd_upper_reg ? (half_wave_top_reg - ram_rdata) : ram_rdata;
        above    = 1'b0;
        diff     = wave_val;
        if (mod_style_reg == STYLE_CENTERED) begin
            above = wave_val > midpoint_level_reg;
            diff  = above ? (wave_val - midpoint_level_reg)
                          : (midpoint_level_reg - wave_val);
        end
    end

    always_comb begin
        mul_valid_next = mul_valid_reg;
        mul_slot_next  = mul_slot_reg;
        mul_above_next = mul_above_reg;
        mul_prod_next  = mul_prod_reg;
        if (adv) begin
            mul_valid_next = rd_valid_reg;
            mul_slot_next  = rd_slot_reg;
            mul_above_next = above;
            mul_prod_next  = 16'(diff) * 16'(rd_duty_reg);
        end
    end

    // ------------------------------------------------------------------
    // final stage: rebuild around midpoint or scale plainly, collect phases
    // ------------------------------------------------------------------
    logic [7:0] scaled;
    logic [7:0] level;
    logic [9:0] cmp_val;

    always_comb begin
        scaled = mul_prod_reg[15:8];
        if (mod_style_reg == STYLE_CENTERED) begin
            level   = mul_above_reg ? (midpoint_level_reg + scaled)
                                    : (midpoint_level_reg - scaled);
            cmp_val = {1'b0, level, 1'b0};
        end else begin
            level   = scaled;
            cmp_val = {level, 2'b00};
        end
    end

    always_comb begin
        asm0_next      = asm0_reg;
        asm1_next      = asm1_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (adv && mul_valid_reg) begin
            case (mul_slot_reg)
                2'd0: asm0_next = cmp_val;
                2'd1: asm1_next = cmp_val;
                default: begin
                    out_valid_next = 1'b1;
                    out_data_next  = {cmp_val, asm1_reg, asm0_reg};
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_valid_reg <= 1'b0;
            iss_cnt_reg   <= SLOT_FIRST;
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            iss_valid_reg <= iss_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_mode_reg  <= iss_mode_next;
        iss_angle_reg <= iss_angle_next;
        iss_duty_reg  <= iss_duty_next;
        iss_ltab_reg  <= iss_ltab_next;
        iss_lidx_reg  <= iss_lidx_next;
        iss_lword_reg <= iss_lword_next;
        rd_slot_reg   <= rd_slot_next;
        rd_upper_reg  <= rd_upper_next;
        rd_duty_reg   <= rd_duty_next;
        mul_slot_reg  <= mul_slot_next;
        mul_above_reg <= mul_above_next;
        mul_prod_reg  <= mul_prod_next;
        asm0_reg      <= asm0_next;
        asm1_reg      <= asm1_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// File: tb/three_phase_wavetable_pwm_test.sv
// ----------------------------------------------------------------------------
// three_phase_wavetable_pwm_test: self-checking bench for the wavetable PWM
// Loads all four quarter-wave tables, then streams compute and load beats
// under several register settings. A scoreboard of predicted compare triples,
// built from a local table shadow, is checked against every result beat.
// ----------------------------------------------------------------------------
module three_phase_wavetable_pwm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import twp_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;  // cycles with no beat, no bus access
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASE_COUNT     = 6;
    localparam int BEATS_PER_PHASE = 60;
    localparam int REPORT_LIMIT    = 30;

    // one input beat, unpacked to fields
    typedef struct packed {
        beat_mode_t mode;
        logic [7:0] angle;
        logic [7:0] duty;
        logic [1:0] load_table;
        logic [6:0] load_index;
        logic [7:0] load_word;
    } pwm_beat_t;

    typedef struct packed {
        logic [9:0] compare_one;
        logic [9:0] compare_two;
        logic [9:0] compare_three;
    } compare_set_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] angle, [15:8] duty, [17:16] load_table, [24:18] load_index,
    // [32:25] load_word, [39:33] zero
    logic [39:0] s_tdata  = '0;
    // [0] mode
    logic [0:0]  s_tuser  = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [9:0] compare_one, [19:10] compare_two, [29:20] compare_three, [31:30] zero
    logic [31:0] m_tdata;

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    initial begin
        forever #10 aclk = ~aclk;
    end

    three_phase_wavetable_pwm dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: shadow of the tables and of the registers
    // ------------------------------------------------------------------
    logic [7:0]   wave_shadow [WAVEFORM_COUNT_DEF][QUARTER_ENTRIES];
    logic [1:0]   sel_shadow   = WAVE_SELECT_RST;
    logic [7:0]   mid_shadow   = MIDPOINT_RST;
    logic [7:0]   top_shadow   = HALF_TOP_RST;
    mod_style_t   style_shadow = STYLE_CENTERED;

    pwm_beat_t    pending_beats[$];      // waiting for the driver
    compare_set_t expected_compares[$];  // predicted, not yet seen

    int fail_count      = 0;
    int reports_left    = REPORT_LIMIT;
    int loads_taken     = 0;
    int loads_dropped   = 0;
    int centered_taken  = 0;
    int sine_taken      = 0;
    int results_checked = 0;
    bit idle_enable     = 1'b1;

    // quarter-wave lookup: mirror in quarters 2 and 4, invert in upper half
    function automatic logic [7:0] folded_word(input logic [7:0] pos);
        logic [6:0] idx;
        logic [7:0] word;
        idx = {1'b0, pos[5:0]};
        if (pos[6]) idx = QUARTER_TOP - idx;
        word = wave_shadow[sel_shadow][idx];
        if (pos[7]) word = top_shadow - word;   // wraps mod 256
        return word;
    endfunction

    // scale around the midpoint, compare = value << 1
    function automatic logic [9:0] centered_compare(input logic [7:0] pos,
                                                    input logic [7:0] duty);
        logic [7:0]  v;
        logic [15:0] r;
        v = folded_word(pos);
        if (v > mid_shadow)
            r = {8'd0, mid_shadow} + ((16'(v - mid_shadow) * duty) >> 8);
        else
            r = {8'd0, mid_shadow} - ((16'(mid_shadow - v) * duty) >> 8);
        return {1'b0, r[7:0], 1'b0};
    endfunction

    // plain scaling, compare = value << 2
    function automatic logic [9:0] sine_compare(input logic [7:0] pos,
                                                input logic [7:0] duty);
        logic [15:0] r;
        r = (16'(folded_word(pos)) * duty) >> 8;
        return {r[7:0], 2'b00};
    endfunction

    // update the shadow for an accepted beat, queue the triple it yields
    function automatic void take_beat(input pwm_beat_t b);
        compare_set_t cs;
        logic [7:0]   pb, pc, pa;
        if (b.mode == MODE_LOAD) begin
            loads_taken++;
            if (b.load_index < QUARTER_ENTRIES)
                wave_shadow[b.load_table][b.load_index] = b.load_word;
            else
                loads_dropped++;
            return;
        end
        pb = b.angle;
        pc = b.angle + PHASE_OFS_THIRD;
        pa = b.angle + PHASE_OFS_TWO3;
        if (style_shadow == STYLE_CENTERED) begin
            centered_taken++;
            cs.compare_one   = centered_compare(pc, b.duty);
            cs.compare_two   = centered_compare(pb, b.duty);
            cs.compare_three = centered_compare(pa, b.duty);
        end else begin
            sine_taken++;
            cs.compare_one   = sine_compare(pb, b.duty);
            cs.compare_two   = sine_compare(pa, b.duty);
            cs.compare_three = sine_compare(pc, b.duty);
        end
        expected_compares.push_back(cs);
    endfunction

    function automatic void check_compares(input logic [31:0] data);
        compare_set_t want;
        logic [9:0]   want_f [3];
        logic [9:0]   got_f  [3];
        string        field_name [3];
        field_name = '{"compare_one", "compare_two", "compare_three"};
        if (expected_compares.size() == 0) begin
            fail_count++;
            if (reports_left > 0) begin
                reports_left--;
                $display("%0t ns: result beat 0x%08h with nothing expected", $time, data);
            end
            return;
        end
        want = expected_compares.pop_front();
        results_checked++;
        want_f = '{want.compare_one, want.compare_two, want.compare_three};
        got_f  = '{data[9:0], data[19:10], data[29:20]};
        for (int i = 0; i < 3; i++) begin
            if (got_f[i] !== want_f[i]) begin
                fail_count++;
                if (reports_left > 0) begin
                    reports_left--;
                    $display("%0t ns: %s expected %0d, got %0d",
                             $time, field_name[i], want_f[i], got_f[i]);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: one beat in flight, with random bursts of idle cycles
    // ------------------------------------------------------------------
    pwm_beat_t  held_beat;
    pwm_beat_t  next_beat;
    logic [2:0] src_gap = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                take_beat(held_beat);
            if (s_tvalid && !s_tready) begin
                // beat stays on the bus until taken
            end else if (src_gap != 0) begin
                src_gap  <= src_gap - 3'd1;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                src_gap  <= 3'($urandom_range(0, 4));
                s_tvalid <= 1'b0;
            end else begin
                next_beat = pending_beats.pop_front();
                held_beat <= next_beat;
                s_tdata   <= {7'd0, next_beat.load_word, next_beat.load_index,
                              next_beat.load_table, next_beat.duty, next_beat.angle};
                s_tuser   <= next_beat.mode;
                s_tvalid  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks every taken beat, stalls in random bursts
    // ------------------------------------------------------------------
    logic [2:0] sink_gap = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= '0;
        end else begin
            if (m_tvalid && m_tready)
                check_compares(m_tdata);
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 3'd1;
                m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                sink_gap <= 3'($urandom_range(0, 4));
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any beat or bus access resets the count
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_CYCLES, expected_compares.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic pwm_beat_t make_load(input logic [1:0] tab, input logic [6:0] idx,
                                            input logic [7:0] word);
        pwm_beat_t b;
        b.mode       = MODE_LOAD;
        b.angle      = 8'($urandom);   // ignored by a load
        b.duty       = 8'($urandom);
        b.load_table = tab;
        b.load_index = idx;
        b.load_word  = word;
        return b;
    endfunction

    function automatic pwm_beat_t make_compute(input logic [7:0] angle,
                                               input logic [7:0] duty);
        pwm_beat_t b;
        b.mode       = MODE_COMPUTE;
        b.angle      = angle;
        b.duty       = duty;
        b.load_table = 2'($urandom);    // load fields are noise here
        b.load_index = 7'($urandom);
        b.load_word  = 8'($urandom);
        return b;
    endfunction

    // mostly computes; loads mostly in range, some past the table end
    function automatic pwm_beat_t random_beat();
        logic [6:0] idx;
        if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 9) == 0)
                return make_compute(8'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00);
            return make_compute(8'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
            idx = 7'($urandom_range(QUARTER_ENTRIES, 127));
        else
            idx = 7'($urandom_range(0, QUARTER_ENTRIES - 1));
        return make_load(2'($urandom), idx, 8'($urandom));
    endfunction

    // wait until nothing is queued, on the bus or outstanding, then let the
    // pipe run dry: trailing loads leave no result to wait for
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || expected_compares.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, access cycle; the register takes it in the access cycle
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_WAVE_SELECT: sel_shadow   = value[1:0];
            REG_MIDPOINT:    mid_shadow   = value[7:0];
            REG_HALF_TOP:    top_shadow   = value[7:0];
            REG_MOD_STYLE:   style_shadow = mod_style_t'(value[0]);
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [1:0] sel, input logic [7:0] mid,
                                 input logic [7:0] top, input mod_style_t style);
        write_reg(REG_WAVE_SELECT, {30'd0, sel});
        write_reg(REG_MIDPOINT,    {24'd0, mid});
        write_reg(REG_HALF_TOP,    {24'd0, top});
        write_reg(REG_MOD_STYLE,   {31'd0, style});
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill every table entry first so no compute reads an unwritten word;
        // ends of each table get the extreme words
        for (int t = 0; t < WAVEFORM_COUNT_DEF; t++)
            for (int i = 0; i < QUARTER_ENTRIES; i++)
                pending_beats.push_back(make_load(2'(t), 7'(i),
                    (i == 0) ? 8'h00 : (i == QUARTER_ENTRIES - 1) ? 8'hFF : 8'($urandom)));

        // directed, reset settings (table 0, centered, midpoint 127, top 255):
        // quarter and half boundaries, duty extremes
        pending_beats.push_back(make_compute(8'd0,   8'd255));
        pending_beats.push_back(make_compute(8'd255, 8'd255));
        pending_beats.push_back(make_compute(8'd63,  8'd255));
        pending_beats.push_back(make_compute(8'd64,  8'd255));
        pending_beats.push_back(make_compute(8'd127, 8'd128));
        pending_beats.push_back(make_compute(8'd128, 8'd128));
        pending_beats.push_back(make_compute(8'd191, 8'd0));
        pending_beats.push_back(make_compute(8'd192, 8'd1));
        pending_beats.push_back(make_compute(8'd170, 8'd200));
        pending_beats.push_back(make_compute(8'd86,  8'd0));
        // loads past the table end are dropped: reads must still see old words
        pending_beats.push_back(make_load(2'd0, 7'd65,  8'hAA));
        pending_beats.push_back(make_load(2'd0, 7'd127, 8'h55));
        pending_beats.push_back(make_compute(8'd64,  8'd255));
        // top entry and first entry rewritten, then read straight away
        pending_beats.push_back(make_load(2'd0, 7'd64, 8'h00));
        pending_beats.push_back(make_load(2'd0, 7'd0,  8'hFF));
        pending_beats.push_back(make_compute(8'd0,   8'd255));
        pending_beats.push_back(make_compute(8'd192, 8'd255));
        pending_beats.push_back(make_load(2'd3, 7'd64, 8'h80));
        pending_beats.push_back(make_compute(8'd255, 8'd0));
        pending_beats.push_back(make_compute(8'd0,   8'd255));
        wait_idle();

        // each phase: drain fully, new register setting, random traffic
        for (int p = 1; p <= PHASE_COUNT; p++) begin
            case (p)
                1: write_setting(2'd1, 8'd0,   8'd0,   STYLE_SINE);      // top 0 wraps
                2: write_setting(2'd2, 8'd255, 8'd128, STYLE_CENTERED);
                3: write_setting(2'd3, 8'd0,   8'd0,   STYLE_CENTERED);
                4: write_setting(2'd0, 8'd255, 8'd255, STYLE_SINE);
                5: write_setting(2'($urandom), 8'($urandom), 8'($urandom),
                                 mod_style_t'($urandom_range(0, 1)));
                default: write_setting(2'($urandom), 8'd128, 8'($urandom),
                                       mod_style_t'($urandom_range(0, 1)));
            endcase
            if (p == PHASE_COUNT)
                idle_enable = 1'b0;   // full-rate tail on both sides
            @(negedge aclk);
            for (int i = 0; i < BEATS_PER_PHASE; i++)
                pending_beats.push_back(random_beat());
            wait_idle();
        end

        $display("Ran %0d table loads (%0d past the table end) and %0d compute beats",
                 loads_taken, loads_dropped, centered_taken + sine_taken);
        $display("over %0d register settings; %0d centered, %0d sine results checked: %0d",
                 PHASE_COUNT + 1, centered_taken, sine_taken, results_checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/twp_pkg.sv
rtl/twp_ram.sv
rtl/three_phase_wavetable_pwm.sv
tb/three_phase_wavetable_pwm_test.sv
